@@ sv/deq_pkg.sv @@
`default_nettype none

package deq_pkg;

  // DEPTH must be a power of two: slot arithmetic wraps by truncation.
  localparam int unsigned DEPTH     = 16;
  localparam int unsigned ITEM_BITS = 32;
  localparam int unsigned PTR_W     = $clog2(DEPTH);
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);
  localparam int unsigned KIND_W    = 3;
  localparam int unsigned STAT_W    = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_PEEK_FRONT = 3'd4,
    KIND_PEEK_BACK  = 3'd5,
    KIND_CLEAR      = 3'd6
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    RSP_OK    = 2'd0,
    RSP_ITEM  = 2'd1,
    RSP_EMPTY = 2'd2,
    RSP_FULL  = 2'd3
  } rsp_status_e;

  // Controller -> datapath
  typedef struct packed {
    logic accept;
    logic push_front;
    logic push_back;
    logic pop_front;
    logic pop_back;
    logic peek_front;
    logic peek_back;
    logic clear;
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic empty;
    logic full;
  } dp_sts_t;

endpackage

`default_nettype wire

@@ sv/deq_req_if.sv @@
`default_nettype none

interface deq_req_if import deq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [ITEM_BITS-1:0] item_in;

  modport source (output valid, output kind, output item_in, input ready);
  modport sink   (input valid, input kind, input item_in, output ready);
endinterface

`default_nettype wire

@@ sv/deq_rsp_if.sv @@
`default_nettype none

interface deq_rsp_if import deq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STAT_W-1:0]    status;
  logic [ITEM_BITS-1:0] item_out;
  logic [CNT_W-1:0]     fill_level;

  modport source (output valid, output status, output item_out, output fill_level,
                  input ready);
  modport sink   (input valid, input status, input item_out, input fill_level,
                  output ready);
endinterface

`default_nettype wire

@@ sv/deq_ctrl.sv @@
`default_nettype none

module deq_ctrl import deq_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              req_valid_i,
  input  wire logic [KIND_W-1:0] req_kind_i,
  output logic                   req_ready_o,
  output logic                   rsp_valid_o,
  input  wire logic              rsp_ready_i,
  output logic [STAT_W-1:0]      rsp_status_o,
  input  wire dp_sts_t           sts_i,
  output dp_cmd_t                cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RESP = 2'b10
  } state_e;

  state_e      state_q, state_d;
  rsp_status_e status_q, status_d;

  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    cmd_o    = '0;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          state_d      = ST_RESP;
          status_d     = RSP_OK;
          cmd_o.accept = 1'b1;
          case (kind_e'(req_kind_i))
            KIND_PUSH_FRONT: begin
              if (sts_i.full) status_d = RSP_FULL;
              else            cmd_o.push_front = 1'b1;
            end
            KIND_PUSH_BACK: begin
              if (sts_i.full) status_d = RSP_FULL;
              else            cmd_o.push_back = 1'b1;
            end
            KIND_POP_FRONT: begin
              if (sts_i.empty) status_d = RSP_EMPTY;
              else begin
                status_d        = RSP_ITEM;
                cmd_o.pop_front = 1'b1;
              end
            end
            KIND_POP_BACK: begin
              if (sts_i.empty) status_d = RSP_EMPTY;
              else begin
                status_d       = RSP_ITEM;
                cmd_o.pop_back = 1'b1;
              end
            end
            KIND_PEEK_FRONT: begin
              if (sts_i.empty) status_d = RSP_EMPTY;
              else begin
                status_d         = RSP_ITEM;
                cmd_o.peek_front = 1'b1;
              end
            end
            KIND_PEEK_BACK: begin
              if (sts_i.empty) status_d = RSP_EMPTY;
              else begin
                status_d        = RSP_ITEM;
                cmd_o.peek_back = 1'b1;
              end
            end
            KIND_CLEAR: cmd_o.clear = 1'b1;
            default: ;  // unused code: no change, status ok
          endcase
        end
      end
      ST_RESP: begin
        if (rsp_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      status_q <= RSP_OK;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
    end
  end

  assign req_ready_o  = (state_q == ST_IDLE);
  assign rsp_valid_o  = (state_q == ST_RESP);
  assign rsp_status_o = status_q;

endmodule

`default_nettype wire

@@ sv/deq_dp.sv @@
`default_nettype none

module deq_dp import deq_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire dp_cmd_t              cmd_i,
  input  wire logic [ITEM_BITS-1:0] item_i,
  output dp_sts_t                   sts_o,
  output logic [ITEM_BITS-1:0]      item_o,
  output logic [CNT_W-1:0]          fill_o
);

  logic [ITEM_BITS-1:0] mem [DEPTH];
  logic [ITEM_BITS-1:0] rd_data_q;
  logic                 item_vld_q;

  logic [PTR_W-1:0] front_q, front_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [PTR_W-1:0] front_m1, front_p1, tail_slot, back_slot;
  logic [PTR_W-1:0] wr_addr, rd_addr;
  logic             wr_en, rd_en;

  assign front_m1  = front_q - PTR_W'(1);
  assign front_p1  = front_q + PTR_W'(1);
  // First free slot behind the back item; back item sits one before it.
  assign tail_slot = front_q + count_q[PTR_W-1:0];
  assign back_slot = tail_slot - PTR_W'(1);

  assign sts_o.empty = (count_q == '0);
  assign sts_o.full  = (count_q == CNT_W'(DEPTH));

  always_comb begin
    front_d = front_q;
    count_d = count_q;
    wr_en   = cmd_i.push_front | cmd_i.push_back;
    wr_addr = cmd_i.push_front ? front_m1 : tail_slot;
    rd_en   = cmd_i.pop_front | cmd_i.pop_back | cmd_i.peek_front | cmd_i.peek_back;
    rd_addr = (cmd_i.pop_back | cmd_i.peek_back) ? back_slot : front_q;
    if (cmd_i.push_front) begin
      front_d = front_m1;
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.push_back) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.pop_front) begin
      front_d = front_p1;
      count_d = count_q - CNT_W'(1);
    end else if (cmd_i.pop_back) begin
      count_d = count_q - CNT_W'(1);
    end else if (cmd_i.clear) begin
      front_d = '0;
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q    <= '0;
      count_q    <= '0;
      item_vld_q <= 1'b0;
    end else begin
      front_q <= front_d;
      count_q <= count_d;
      if (cmd_i.accept) item_vld_q <= rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= item_i;
    if (rd_en) rd_data_q <= mem[rd_addr];
  end

  assign item_o = item_vld_q ? rd_data_q : '0;
  assign fill_o = count_q;

endmodule

`default_nettype wire

@@ sv/double_ended_queue.sv @@
// Double-ended queue of DEPTH item handles kept in a ring buffer.
// Request channel (req_i): kind selects push front/back, pop front/back,
// peek front/back or clear; item_in carries the handle for a push.
// Response channel (rsp_o): one transfer per request with status
// (ok, item returned, empty error, full error), item_out (zero unless an
// item is returned) and fill_level after the request.
// Timing: the response to a request transfer is registered, and so is the
// ring memory's read of its item. One request is in flight at a time: the
// controller's IDLE and RESP states take a new request only after the
// last response has transferred.
// req_i.ready is low while a response waits; a stalled receiver holds the
// response and its payload stable and blocks further requests.
// Reset empties the queue (front slot and fill count to zero); the memory
// contents are not cleared and only occupied slots are ever read.
`default_nettype none

module double_ended_queue import deq_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  deq_req_if.sink   req_i,
  deq_rsp_if.source rsp_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  deq_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_i.valid),
    .req_kind_i   (req_i.kind),
    .req_ready_o  (req_i.ready),
    .rsp_valid_o  (rsp_o.valid),
    .rsp_ready_i  (rsp_o.ready),
    .rsp_status_o (rsp_o.status),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  deq_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .item_i (req_i.item_in),
    .sts_o  (sts),
    .item_o (rsp_o.item_out),
    .fill_o (rsp_o.fill_level)
  );

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rsp_o.valid && req_i.ready))
    else $error("request taken while a response is pending");

  a_resp_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> rsp_o.valid)
    else $error("no response after request transfer");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.fill_level <= CNT_W'(DEPTH))
    else $error("fill level beyond depth");

  a_item_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status != RSP_ITEM) |-> rsp_o.item_out == '0)
    else $error("item returned without item status");

endmodule

`default_nettype wire

@@ sim/double_ended_queue_test.sv @@
`timescale 1ns / 100ps

module double_ended_queue_test;
  import deq_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;
  localparam int unsigned RANDOM_REQUESTS   = 1000;
  localparam int unsigned PRESSURE_AT       = 350;
  localparam int unsigned STALL_HOLD_CYCLES = 300;
  localparam int unsigned IDLE_LIMIT        = 3000;
  localparam int unsigned DRAIN_CYCLES      = 20;
  localparam int unsigned MAX_REPORTS       = 10;

  typedef struct packed {
    rsp_status_e          status;
    logic [ITEM_BITS-1:0] item;
    logic [CNT_W-1:0]     fill;
  } deq_rsp_t;

  typedef struct {
    logic [KIND_W-1:0]    kind;
    logic [ITEM_BITS-1:0] item;
    int unsigned          reps;
    bit                   typed;
    deq_rsp_t             rsp;
  } stim_row_t;

  // Rows with typed == 0 are checked against the shadow queue.
  // Repeated rows push item, item + 1, ...
  stim_row_t directed_rows [24] = '{
    '{KIND_POP_FRONT,  32'h0,          1,  1'b1, '{RSP_EMPTY, '0, '0}},
    '{KIND_POP_BACK,   32'h0,          1,  1'b1, '{RSP_EMPTY, '0, '0}},
    '{KIND_PEEK_FRONT, 32'h0,          1,  1'b1, '{RSP_EMPTY, '0, '0}},
    '{KIND_PEEK_BACK,  32'h0,          1,  1'b1, '{RSP_EMPTY, '0, '0}},
    '{KIND_UNUSED,     32'hFFFF_FFFF,  1,  1'b1, '{RSP_OK,    '0, '0}},
    '{KIND_CLEAR,      32'h0,          1,  1'b1, '{RSP_OK,    '0, '0}},
    // front pointer wraps below slot zero
    '{KIND_PUSH_FRONT, 32'hFFFF_FFFF,  1,  1'b1, '{RSP_OK,    '0, 5'd1}},
    '{KIND_PUSH_BACK,  32'h0,          1,  1'b1, '{RSP_OK,    '0, 5'd2}},
    '{KIND_PEEK_FRONT, 32'h0,          1,  1'b1, '{RSP_ITEM,  32'hFFFF_FFFF, 5'd2}},
    '{KIND_PEEK_BACK,  32'h0,          1,  1'b1, '{RSP_ITEM,  32'h0, 5'd2}},
    '{KIND_POP_BACK,   32'h0,          1,  1'b1, '{RSP_ITEM,  32'h0, 5'd1}},
    '{KIND_POP_FRONT,  32'h0,          1,  1'b1, '{RSP_ITEM,  32'hFFFF_FFFF, 5'd0}},
    '{KIND_PUSH_BACK,  32'h5A5A_0000,  10, 1'b0, '{RSP_OK,    '0, '0}},
    '{KIND_PUSH_FRONT, 32'hC3C3_0000,  6,  1'b0, '{RSP_OK,    '0, '0}},
    '{KIND_PUSH_FRONT, 32'h1234_5678,  1,  1'b1, '{RSP_FULL,  '0, 5'd16}},
    '{KIND_PUSH_BACK,  32'h8765_4321,  1,  1'b1, '{RSP_FULL,  '0, 5'd16}},
    '{KIND_PEEK_BACK,  32'h0,          1,  1'b0, '{RSP_OK,    '0, '0}},
    '{KIND_POP_BACK,   32'h0,          8,  1'b0, '{RSP_OK,    '0, '0}},
    '{KIND_POP_FRONT,  32'h0,          3,  1'b0, '{RSP_OK,    '0, '0}},
    '{KIND_UNUSED,     32'h0,          1,  1'b0, '{RSP_OK,    '0, '0}},
    '{KIND_CLEAR,      32'h0,          1,  1'b1, '{RSP_OK,    '0, '0}},
    '{KIND_POP_BACK,   32'h0,          1,  1'b1, '{RSP_EMPTY, '0, '0}},
    '{KIND_PUSH_FRONT, 32'hA5A5_A5A5,  1,  1'b0, '{RSP_OK,    '0, '0}},
    '{KIND_POP_BACK,   32'h0,          1,  1'b0, '{RSP_OK,    '0, '0}}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #1 clk_i = ~clk_i;

  deq_req_if req_bus ();
  deq_rsp_if rsp_bus ();

  double_ended_queue dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  // Shadow copy of the ring buffer
  logic [ITEM_BITS-1:0] shadow_store [DEPTH];
  logic [PTR_W-1:0]     shadow_front;
  logic [CNT_W-1:0]     shadow_count;

  deq_rsp_t    expected_responses [$];
  int unsigned mismatch_count;
  int unsigned idle_cycles;
  int unsigned burst_left;
  bit          hold_responses;

  function automatic deq_rsp_t apply_request(input logic [KIND_W-1:0] kind,
                                             input logic [ITEM_BITS-1:0] item);
    deq_rsp_t         rsp;
    logic [PTR_W-1:0] slot;
    rsp = '{RSP_OK, '0, '0};
    case (kind)
      KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
        if (shadow_count >= CNT_W'(DEPTH)) begin
          rsp.status = RSP_FULL;
        end else begin
          if (kind == KIND_PUSH_FRONT) begin
            shadow_front = shadow_front - PTR_W'(1);
            slot = shadow_front;
          end else begin
            slot = shadow_front + shadow_count[PTR_W-1:0];
          end
          shadow_store[slot] = item;
          shadow_count++;
        end
      end
      KIND_POP_FRONT, KIND_PEEK_FRONT, KIND_POP_BACK, KIND_PEEK_BACK: begin
        if (shadow_count == '0) begin
          rsp.status = RSP_EMPTY;
        end else begin
          if (kind == KIND_POP_FRONT || kind == KIND_PEEK_FRONT) begin
            slot = shadow_front;
          end else begin
            slot = shadow_front + shadow_count[PTR_W-1:0] - PTR_W'(1);
          end
          rsp.status = RSP_ITEM;
          rsp.item   = shadow_store[slot];
          if (kind == KIND_POP_FRONT) begin
            shadow_front = shadow_front + PTR_W'(1);
          end
          if (kind == KIND_POP_FRONT || kind == KIND_POP_BACK) begin
            shadow_count--;
          end
        end
      end
      KIND_CLEAR: begin
        shadow_front = '0;
        shadow_count = '0;
      end
      default: begin
      end
    endcase
    rsp.fill = shadow_count;
    return rsp;
  endfunction

  // Holds the request until it transfers, then opens a gap at burst ends.
  task automatic offer_request(input logic [KIND_W-1:0] kind,
                               input logic [ITEM_BITS-1:0] item,
                               input bit typed, input deq_rsp_t typed_rsp);
    deq_rsp_t    predicted;
    int unsigned gap;
    req_bus.valid   <= 1'b1;
    req_bus.kind    <= kind;
    req_bus.item_in <= item;
    do @(posedge clk_i); while (req_bus.ready !== 1'b1);
    predicted = apply_request(kind, item);
    expected_responses.push_back(typed ? typed_rsp : predicted);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        req_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(0, 24);
    end
  endtask

  initial begin
    int unsigned          counted;
    int unsigned          segment_left;
    int unsigned          push_pct;
    int unsigned          roll;
    logic [KIND_W-1:0]    kind;
    logic [ITEM_BITS-1:0] item;
    req_bus.valid   = 1'b0;
    req_bus.kind    = KIND_PUSH_FRONT;
    req_bus.item_in = '0;
    shadow_front    = '0;
    shadow_count    = '0;
    foreach (shadow_store[s]) shadow_store[s] = '0;
    mismatch_count  = 0;
    burst_left      = 0;
    hold_responses  = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      for (int i = 0; i < directed_rows[r].reps; i++) begin
        offer_request(directed_rows[r].kind, directed_rows[r].item + i,
                      directed_rows[r].typed, directed_rows[r].rsp);
      end
    end

    // Segments lean toward filling, draining or neither so that full and
    // empty are both hit often.
    counted      = 0;
    segment_left = 0;
    push_pct     = 50;
    while (counted < RANDOM_REQUESTS) begin
      if (segment_left == 0) begin
        case ($urandom_range(0, 2))
          0:       push_pct = 75;
          1:       push_pct = 25;
          default: push_pct = 50;
        endcase
        segment_left = $urandom_range(20, 60);
      end
      segment_left--;
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        kind = KIND_CLEAR;
      end else if (roll < 4) begin
        kind = KIND_UNUSED;
      end else if ($urandom_range(0, 99) < push_pct) begin
        kind = $urandom_range(0, 1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
      end else begin
        case ($urandom_range(0, 5))
          0, 1:    kind = KIND_POP_FRONT;
          2, 3:    kind = KIND_POP_BACK;
          4:       kind = KIND_PEEK_FRONT;
          default: kind = KIND_PEEK_BACK;
        endcase
      end
      case ($urandom_range(0, 15))
        0:       item = '0;
        1:       item = '1;
        default: item = $urandom;
      endcase
      if (counted == PRESSURE_AT && kind != KIND_UNUSED) begin
        hold_responses = 1'b1;
      end
      offer_request(kind, item, 1'b0, '0);
      if (kind != KIND_UNUSED) begin
        counted++;
      end
    end
    req_bus.valid <= 1'b0;

    while (expected_responses.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Response side stall pattern; one long hold-off on request.
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    int unsigned phase;
    rsp_bus.ready = 1'b0;
    mode          = 0;
    mode_left     = 0;
    phase         = 0;
    forever begin
      @(posedge clk_i);
      if (hold_responses) begin
        rsp_bus.ready <= 1'b0;
        repeat (STALL_HOLD_CYCLES) @(posedge clk_i);
        hold_responses = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        phase++;
        case (mode)
          0:       rsp_bus.ready <= 1'b1;
          1:       rsp_bus.ready <= 1'($urandom_range(0, 1));
          2:       rsp_bus.ready <= ($urandom_range(0, 3) == 0);
          default: rsp_bus.ready <= ((phase % 5) < 3);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    deq_rsp_t want;
    if (rst_ni && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      if (expected_responses.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("unexpected response transfer: status %0d item %h fill %0d",
                   rsp_bus.status, rsp_bus.item_out, rsp_bus.fill_level);
        end
      end else begin
        want = expected_responses.pop_front();
        if (rsp_bus.status !== want.status || rsp_bus.item_out !== want.item ||
            rsp_bus.fill_level !== want.fill) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("response mismatch: status %0d (exp %0d) item %h (exp %h) fill %0d (exp %0d)",
                     rsp_bus.status, want.status, rsp_bus.item_out, want.item,
                     rsp_bus.fill_level, want.fill);
          end
        end
      end
    end

    // watchdog: cycles without any transfer
    if (rst_ni && ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
                   (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles, %0d responses outstanding",
               idle_cycles, expected_responses.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule
